// ===== src/rvw_pkg.sv =====
package rvw_pkg;

  // input word kinds
  localparam logic [1:0] KIND_STEP  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_RESET_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS    = 2'd1;

  localparam int VOLT_W  = 10;
  localparam int TICK_W  = 8;
  localparam int COUNT_W = 32;

  // threshold ceiling
  localparam logic [VOLT_W-1:0] VOLT_CEILING = VOLT_W'(800);

  // phase codes as seen on the result word
  localparam logic [2:0] PHASE_OFF  = 3'd0;
  localparam logic [2:0] PHASE_INIT = 3'd1;
  localparam logic [2:0] PHASE_RISE = 3'd2;
  localparam logic [2:0] PHASE_FALL = 3'd3;
  localparam logic [2:0] PHASE_HOLD = 3'd4;

endpackage

// ===== src/relay_voltage_watchdog.sv =====
// relay voltage watchdog: phase machine that opens a relay on a bus voltage dip
// a result word is registered when its input word is taken
// throughput: one word per cycle while the result channel does not stall; the phase
//   update and the 8-bit tick compare sit between the state registers and the result register
// reset (rst, synchronous, active high): phase off, relay closed, stamp and
//   activation count zero, both config registers zero, no result pending
module relay_voltage_watchdog
  import rvw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input word channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [15:0]         bus_voltage,
  input  logic [TICK_W-1:0]   tick_now,
  // result word channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                relay_open,
  output logic                watchdog_active,
  output logic [2:0]          phase_code,
  output logic [COUNT_W-1:0]  activation_count,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [VOLT_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_OFF  = PHASE_OFF,
    ST_INIT = PHASE_INIT,
    ST_RISE = PHASE_RISE,
    ST_FALL = PHASE_FALL,
    ST_HOLD = PHASE_HOLD
  } phase_t;

  // watchdog state
  phase_t              phase, phase_next;
  logic                relay_level, relay_level_next;
  logic [TICK_W-1:0]   open_stamp, open_stamp_next;
  logic [COUNT_W-1:0]  openings, openings_next;

  // configuration
  logic [VOLT_W-1:0]   reset_voltage;
  logic [TICK_W-1:0]   hold_ticks;

  logic                in_take;
  logic                cfg_take;
  logic [TICK_W-1:0]   elapsed;
  logic                rise_seen;
  logic                fall_seen;
  logic                hold_done;

  // the result register can take a new word when empty or when it drains now
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;

  // threshold compares against the full 16-bit sample
  assign rise_seen = bus_voltage > {6'd0, reset_voltage};
  assign fall_seen = bus_voltage < {6'd0, reset_voltage};

  // ticks since the relay opened, modulo 256
  assign elapsed   = tick_now - open_stamp;
  assign hold_done = elapsed >= hold_ticks;

  always_comb begin
    phase_next       = phase;
    relay_level_next = relay_level;
    open_stamp_next  = open_stamp;
    openings_next    = openings;
    unique case (kind)
      KIND_STEP: begin
        unique case (phase)
          ST_INIT: begin
            // close the relay, sample not looked at on this step
            relay_level_next = 1'b0;
            phase_next       = ST_RISE;
          end
          ST_RISE: begin
            if (rise_seen) begin
              phase_next = ST_FALL;
            end
          end
          ST_FALL: begin
            // dip below threshold: open the relay and stamp the tick
            if (fall_seen) begin
              relay_level_next = 1'b1;
              openings_next    = openings + COUNT_W'(1);
              open_stamp_next  = tick_now;
              phase_next       = ST_HOLD;
            end
          end
          ST_HOLD: begin
            if (hold_done) begin
              relay_level_next = 1'b0;
              phase_next       = ST_RISE;
            end
          end
          default: begin
            // off: steps change nothing
          end
        endcase
      end
      KIND_START: begin
        // start only leaves the off phase, ignored while running
        if (phase == ST_OFF) begin
          phase_next = ST_INIT;
        end
      end
      KIND_STOP: begin
        // count and stamp are kept
        phase_next       = ST_OFF;
        relay_level_next = 1'b0;
      end
      default: begin
        // clear count, phase and relay untouched
        openings_next = '0;
      end
    endcase
  end

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ST_OFF;
      relay_level   <= 1'b0;
      open_stamp    <= '0;
      openings      <= '0;
      reset_voltage <= '0;
      hold_ticks    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_take) begin
        case (cfg_index)
          REG_RESET_VOLTAGE: begin
            reset_voltage <= (cfg_data > VOLT_CEILING) ? VOLT_CEILING : cfg_data;
          end
          REG_HOLD_TICKS: begin
            hold_ticks <= cfg_data[TICK_W-1:0];
          end
          default: begin
            // unknown register, write dropped
          end
        endcase
      end
      if (in_take) begin
        phase       <= phase_next;
        relay_level <= relay_level_next;
        open_stamp  <= open_stamp_next;
        openings    <= openings_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with the state after the update
  always_ff @(posedge clk) begin
    if (in_take) begin
      relay_open       <= relay_level_next;
      watchdog_active  <= (phase_next != ST_OFF);
      phase_code       <= phase_next;
      activation_count <= openings_next;
    end
  end

`ifndef SYNTHESIS
  // the relay is open exactly while holding
  a_relay_only_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_open == (phase_code == PHASE_HOLD)))
    else $error("relay open outside hold phase");

  // the activation count only steps by one or clears
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (openings == $past(openings)) ||
                    (openings == $past(openings) + COUNT_W'(1)) ||
                    (openings == '0))
    else $error("activation count jumped");

  // the relay only opens on a step taken in the wait-fall phase
  a_open_from_fall: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(relay_level) |->
      $past(in_take) && $past(phase) == ST_FALL && $past(kind) == KIND_STEP)
    else $error("relay opened outside a falling step");

  // threshold never holds a value above the ceiling
  a_threshold_cap: assert property (@(posedge clk) disable iff (rst)
    cfg_take |=> reset_voltage <= VOLT_CEILING)
    else $error("threshold above ceiling");
`endif

endmodule
